// File: sv/amgd_pkg.sv
// Package: types, constants and status codes for the graph store.
package amgd_pkg;
   localparam int DefMaxVertices = 16;

   typedef enum logic [1:0] {
      CMD_ADD_VERTEX = 2'd0,
      CMD_ADD_EDGE   = 2'd1,
      CMD_REMOVE     = 2'd2,
      CMD_WALK       = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_FULL        = 3'd1,
      ST_EXISTS      = 3'd2,
      ST_MISSING     = 3'd3,
      ST_EDGE_EXISTS = 3'd4,
      ST_EMPTY       = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEARCH,
      S_DECIDE,
      S_SHIFT,
      S_COLS,
      S_WALK_START,
      S_WALK_STEP,
      S_WALK_EMIT,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] label_a;
      logic [7:0] label_b;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] vertex_label;
      logic       is_last;
      logic [4:0] vertex_count;
   } rsp_type;
endpackage

// File: sv/amgd_if.sv
// Interface: valid/ready channel carrying one payload word.
interface amgd_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: sv/adjacency_matrix_graph_dfs.sv
// Top level: undirected graph store with depth-first walk.
//
// Usage:
//   req (sink): one word per command (command, label_a, label_b).
//   rsp (source): status, vertex_label, is_last, vertex_count per word.
//   Add vertex / add edge / remove give exactly one rsp word with is_last.
//   Walk gives one word per visited vertex, is_last on the final one;
//   an empty graph gives one word with status "graph empty".
// Timing: one command at a time; req_ready is high only while idle.
//   Label search steps one entry per cycle over the stored vertices; add
//   vertex / add edge then pass a decide state and load their rsp word in
//   the response state. Remove, after the decide state, shifts labels/rows
//   one entry per cycle and drops the column one row per cycle. Walk marks
//   vertex 0 in a start state; each further vertex passes a step and an emit
//   state, and each backtrack pops the stack in the step state; each walk
//   word is held back until the next visit so is_last can be set once the
//   stack empties.
// Stall: each rsp word is held in an output register until rsp_ready; the
//   sequencer waits on it, nothing is lost.
// Reset: synchronous; clears vertex count, adjacency rows and visited marks.
//   Labels and stack are undefined until written.
module adjacency_matrix_graph_dfs
   import amgd_pkg::*;
#(
   parameter int MAX_VERTICES = DefMaxVertices
) (
   input logic   clock,
   input logic   reset,
   amgd_if.sink   req,
   amgd_if.source rsp
);
   localparam int IW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);

   state_type state_ff, state_in;
   logic [7:0]              labels_ff [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] rows_ff [MAX_VERTICES];
   logic [IW-1:0]           stack_ff [MAX_VERTICES];
   logic [CW-1:0]           used_ff;
   logic [MAX_VERTICES-1:0] visited_ff;
   logic [CW-1:0]           depth_ff;
   req_type                 cmd_ff;
   logic [CW-1:0]           idx_ff;
   logic [IW-1:0]           ia_ff, ib_ff;
   logic                    fa_ff, fb_ff;
   logic [IW-1:0]           rem_ff;
   logic [IW-1:0]           pick_ff;
   logic [7:0]              pend_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;
   status_type              st_ff;

   logic [IW-1:0]           idx_lo;
   logic [MAX_VERTICES-1:0] valid_mask, cand;
   logic [IW-1:0]           top_v, pick;
   logic                    cand_any;
   logic                    out_free;
   logic                    rsp_load;

   assign idx_lo   = idx_ff[IW-1:0];
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE) && out_free;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   always_comb begin
      valid_mask = '0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
         valid_mask[i] = (CW'(i) < used_ff);
      end
   end
   assign top_v = stack_ff[depth_ff[IW-1:0] - IW'(1)];
   assign cand  = rows_ff[top_v] & valid_mask & ~visited_ff;
   assign cand_any = |cand;
   always_comb begin
      pick = '0;
      for (int j = MAX_VERTICES - 1; j >= 0; j--) begin
         if (cand[j]) begin
            pick = IW'(j);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req.valid && out_free) begin
               state_in = (cmd_type'(req.payload.command) == CMD_WALK) ? S_WALK_START
                                                                     : S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (idx_ff >= used_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (cmd_type'(cmd_ff.command) == CMD_REMOVE && fa_ff) begin
               state_in = S_SHIFT;
            end else begin
               state_in = S_RESP;
            end
         end
         S_SHIFT: begin
            if (idx_ff + CW'(1) >= used_ff) begin
               state_in = S_COLS;
            end
         end
         S_COLS: begin
            if (idx_ff + CW'(1) >= used_ff) begin
               state_in = S_RESP;
            end
         end
         S_WALK_START: begin
            if (used_ff != '0) begin
               state_in = S_WALK_STEP;
            end else if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_WALK_STEP: begin
            if (depth_ff == '0) begin
               if (out_free) begin
                  state_in = S_IDLE;
               end
            end else if (cand_any) begin
               state_in = S_WALK_EMIT;
            end
         end
         S_WALK_EMIT: begin
            if (out_free) begin
               state_in = S_WALK_STEP;
            end
         end
         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output register load strobe
   always_comb begin
      case (state_ff)
         S_WALK_START: rsp_load = out_free && (used_ff == '0);
         S_WALK_STEP:  rsp_load = out_free && (depth_ff == '0);
         S_WALK_EMIT:  rsp_load = out_free;
         S_RESP:       rsp_load = out_free;
         default:      rsp_load = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath and outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         visited_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         depth_ff     <= '0;
         for (int i = 0; i < MAX_VERTICES; i++) begin
            rows_ff[i] <= '0;
         end
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req.valid && out_free) begin
                  cmd_ff <= req.payload;
                  idx_ff <= '0;
                  fa_ff  <= 1'b0;
                  fb_ff  <= 1'b0;
               end
            end
            S_SEARCH: begin
               if (idx_ff < used_ff) begin
                  if (!fa_ff && labels_ff[idx_lo] == cmd_ff.label_a) begin
                     fa_ff <= 1'b1;
                     ia_ff <= idx_lo;
                  end
                  if (!fb_ff && labels_ff[idx_lo] == cmd_ff.label_b) begin
                     fb_ff <= 1'b1;
                     ib_ff <= idx_lo;
                  end
                  idx_ff <= idx_ff + CW'(1);
               end
            end
            S_DECIDE: begin
               case (cmd_type'(cmd_ff.command))
                  CMD_ADD_VERTEX: begin
                     if (used_ff >= CW'(MAX_VERTICES)) begin
                        st_ff <= ST_FULL;
                     end else if (fa_ff) begin
                        st_ff <= ST_EXISTS;
                     end else begin
                        st_ff <= ST_OK;
                        labels_ff[used_ff[IW-1:0]] <= cmd_ff.label_a;
                        used_ff <= used_ff + CW'(1);
                     end
                  end
                  CMD_ADD_EDGE: begin
                     if (!fa_ff || !fb_ff) begin
                        st_ff <= ST_MISSING;
                     end else if (rows_ff[ia_ff][ib_ff]) begin
                        st_ff <= ST_EDGE_EXISTS;
                     end else begin
                        st_ff <= ST_OK;
                        rows_ff[ia_ff][ib_ff] <= 1'b1;
                        rows_ff[ib_ff][ia_ff] <= 1'b1;
                     end
                  end
                  CMD_REMOVE: begin
                     if (!fa_ff) begin
                        st_ff <= ST_MISSING;
                     end else begin
                        st_ff <= ST_OK;
                        rem_ff <= ia_ff;
                        idx_ff <= {1'b0, ia_ff};
                     end
                  end
                  default: st_ff <= ST_OK;
               endcase
            end
            S_SHIFT: begin
               // one row/label moved down per cycle
               if (idx_ff + CW'(1) < used_ff) begin
                  labels_ff[idx_lo] <= labels_ff[idx_lo + IW'(1)];
                  rows_ff[idx_lo]   <= rows_ff[idx_lo + IW'(1)];
                  idx_ff <= idx_ff + CW'(1);
               end else begin
                  rows_ff[idx_lo] <= '0;
                  idx_ff <= '0;
               end
            end
            S_COLS: begin
               // drop column rem from one row per cycle
               for (int j = 0; j < MAX_VERTICES; j++) begin
                  if (IW'(j) < rem_ff) begin
                     rows_ff[idx_lo][j] <= rows_ff[idx_lo][j];
                  end else if (j + 1 < MAX_VERTICES && CW'(j + 1) < used_ff) begin
                     rows_ff[idx_lo][j] <= rows_ff[idx_lo][j+1];
                  end else begin
                     rows_ff[idx_lo][j] <= 1'b0;
                  end
               end
               idx_ff <= idx_ff + CW'(1);
               if (idx_ff + CW'(1) >= used_ff) begin
                  used_ff <= used_ff - CW'(1);
               end
            end
            S_WALK_START: begin
               if (used_ff == '0) begin
                  if (out_free) begin
                     rsp_ff.status       <= ST_EMPTY;
                     rsp_ff.vertex_label <= '0;
                     rsp_ff.is_last      <= 1'b1;
                     rsp_ff.vertex_count <= 5'(used_ff);
                  end
               end else begin
                  // vertex 0 word waits until the next visit or the end
                  pend_ff     <= labels_ff[0];
                  visited_ff  <= MAX_VERTICES'(1);
                  stack_ff[0] <= '0;
                  depth_ff    <= CW'(1);
               end
            end
            S_WALK_STEP: begin
               if (depth_ff == '0) begin
                  // stack empty: held word is the final one
                  if (out_free) begin
                     rsp_ff.status       <= ST_OK;
                     rsp_ff.vertex_label <= pend_ff;
                     rsp_ff.is_last      <= 1'b1;
                     rsp_ff.vertex_count <= 5'(used_ff);
                  end
               end else if (cand_any) begin
                  pick_ff <= pick;
                  visited_ff[pick] <= 1'b1;
                  if (depth_ff < CW'(MAX_VERTICES)) begin
                     stack_ff[depth_ff[IW-1:0]] <= pick;
                     depth_ff <= depth_ff + CW'(1);
                  end
               end else begin
                  depth_ff <= depth_ff - CW'(1);
               end
            end
            S_WALK_EMIT: begin
               // another vertex follows, so the held word is not last
               if (out_free) begin
                  rsp_ff.status       <= ST_OK;
                  rsp_ff.vertex_label <= pend_ff;
                  rsp_ff.is_last      <= 1'b0;
                  rsp_ff.vertex_count <= 5'(used_ff);
                  pend_ff             <= labels_ff[pick_ff];
               end
            end
            S_RESP: begin
               if (out_free) begin
                  rsp_ff.status       <= st_ff;
                  rsp_ff.vertex_label <= '0;
                  rsp_ff.is_last      <= 1'b1;
                  rsp_ff.vertex_count <= 5'(used_ff);
               end
            end
            default: ;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset) used_ff <= CW'(MAX_VERTICES))
      else $error("vertex count overflow");
   assert property (@(posedge clock) disable iff (reset) depth_ff <= CW'(MAX_VERTICES))
      else $error("stack overflow");
   assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == S_IDLE)
      else $error("ready while busy");
endmodule

// File: tb/tb_amgd_board.sv
// Scoreboard class: graph-store predictor and queue of expected response words.
`timescale 1ns / 100ps
package tb_amgd_board_pkg;
   import amgd_pkg::*;

   class graph_board;
      localparam int NV = DefMaxVertices;
      logic [7:0]    labels[NV];
      logic [NV-1:0] rows[NV];
      int            used;
      rsp_type       pending[$];
      int            errors;
      int            walks_done;

      function new();
         errors = 0;
         walks_done = 0;
         used = 0;
         foreach (rows[i]) begin
            rows[i] = '0;
            labels[i] = '0;
         end
      endfunction

      function int find_label(logic [7:0] lbl);
         for (int i = 0; i < used; i++) begin
            if (labels[i] == lbl) return i;
         end
         return -1;
      endfunction

      function void push_word(status_type st, logic [7:0] lbl, logic last);
         rsp_type w;
         w.status = st;
         w.vertex_label = lbl;
         w.is_last = last;
         w.vertex_count = used[4:0];
         pending.push_back(w);
      endfunction

      // Depth-first from vertex 0, lowest neighbor first; marks fresh per walk.
      function void walk_graph();
         logic [NV-1:0] seen;
         logic [NV-1:0] live;
         logic [NV-1:0] cand;
         int            path[$];
         int            v;
         int            j;
         live = (used >= NV) ? '1 : ((NV'(1) << used) - 1);
         seen = NV'(1);
         path.push_back(0);
         push_word(ST_OK, labels[0], 1'b0);
         while (path.size() > 0) begin
            v = path[$];
            cand = rows[v] & live & ~seen;
            if (cand == '0) begin
               void'(path.pop_back());
            end else begin
               j = 0;
               while (!cand[j]) j++;
               seen[j] = 1'b1;
               path.push_back(j);
               push_word(ST_OK, labels[j], 1'b0);
            end
         end
         pending[$].is_last = 1'b1;
         walks_done++;
      endfunction

      function void note_command(req_type r);
         status_type    st;
         int            ia;
         int            ib;
         logic [NV-1:0] row;
         st = ST_OK;
         case (cmd_type'(r.command))
            CMD_ADD_VERTEX: begin
               if (used >= NV) st = ST_FULL;
               else if (find_label(r.label_a) >= 0) st = ST_EXISTS;
               else begin
                  labels[used] = r.label_a;
                  used++;
               end
            end
            CMD_ADD_EDGE: begin
               ia = find_label(r.label_a);
               ib = find_label(r.label_b);
               if (ia < 0 || ib < 0) st = ST_MISSING;
               else if (rows[ia][ib]) st = ST_EDGE_EXISTS;
               else begin
                  rows[ia][ib] = 1'b1;
                  rows[ib][ia] = 1'b1;
               end
            end
            CMD_REMOVE: begin
               ia = find_label(r.label_a);
               if (ia < 0) st = ST_MISSING;
               else begin
                  for (int i = ia; i + 1 < used; i++) begin
                     labels[i] = labels[i+1];
                     rows[i] = rows[i+1];
                  end
                  rows[used-1] = '0;
                  for (int i = 0; i < NV; i++) begin
                     row = '0;
                     for (int k = 0; k < NV; k++) begin
                        if (k < ia) row[k] = rows[i][k];
                        else if (k + 1 < NV) row[k] = rows[i][k+1];
                     end
                     for (int k = used - 1; k < NV; k++) row[k] = 1'b0;
                     rows[i] = row;
                  end
                  used--;
               end
            end
            default: begin
               if (used == 0) st = ST_EMPTY;
               else begin
                  walk_graph();
                  return;
               end
            end
         endcase
         push_word(st, 8'd0, 1'b1);
      endfunction

      function void check_word(rsp_type got);
         rsp_type exp_w;
         if (pending.size() == 0) begin
            $error("unexpected response word %p", got);
            errors++;
            return;
         end
         exp_w = pending.pop_front();
         if (got.status !== exp_w.status) begin
            $error("status: expected %0d, got %0d", exp_w.status, got.status);
            errors++;
         end
         if (got.vertex_label !== exp_w.vertex_label) begin
            $error("vertex_label: expected %0d, got %0d", exp_w.vertex_label,
                   got.vertex_label);
            errors++;
         end
         if (got.is_last !== exp_w.is_last) begin
            $error("is_last: expected %0d, got %0d", exp_w.is_last, got.is_last);
            errors++;
         end
         if (got.vertex_count !== exp_w.vertex_count) begin
            $error("vertex_count: expected %0d, got %0d", exp_w.vertex_count,
                   got.vertex_count);
            errors++;
         end
      endfunction
   endclass
endpackage

// File: tb/tb.sv
// Testbench top: drives graph commands and checks every response word.
`timescale 1ns / 100ps
module tb;
   import amgd_pkg::*;
   import tb_amgd_board_pkg::*;

   localparam int CycleLimit = 400000;

   logic clock;
   logic reset;
   amgd_if #(.payload_type(req_type)) req ();
   amgd_if #(.payload_type(rsp_type)) rsp ();

   adjacency_matrix_graph_dfs u_top (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   graph_board board;
   int         send_idle_pct;   // sender gap odds, percent
   int         recv_stall_pct;  // receiver stall odds, percent
   int         hold_off;        // cycles of forced back-pressure left
   int         cycles;
   logic [7:0] pool[$];         // labels that the random part tends to reuse

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CycleLimit) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Response side: stalls at random, or for a long forced stretch.
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            hold_off--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Checks each accepted response word at the rising edge.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready) board.check_word(rsp.payload);
      end
   end

   // One command word; valid stays high until accepted, predictor updated then.
   // Valid drops only for idle gaps; back-to-back words keep it high.
   task automatic send_cmd(cmd_type c, logic [7:0] a, logic [7:0] b);
      req_type r;
      r.command = c;
      r.label_a = a;
      r.label_b = b;
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.payload <= r;
      req.valid <= 1'b1;
      do @(posedge clock); while (!req.ready);
      board.note_command(r);
      @(negedge clock);
   endtask

   function automatic logic [7:0] pick_label();
      if (pool.size() > 0 && $urandom_range(99) < 80)
         return pool[$urandom_range(pool.size() - 1)];
      return 8'($urandom);
   endfunction

   // Mostly builds and walks a graph over a small label pool.
   task automatic random_cmd();
      int  r;
      r = $urandom_range(99);
      if (r < 35) send_cmd(CMD_ADD_VERTEX, pick_label(), 8'($urandom));
      else if (r < 70) send_cmd(CMD_ADD_EDGE, pick_label(), pick_label());
      else if (r < 82) send_cmd(CMD_REMOVE, pick_label(), 8'($urandom));
      else send_cmd(CMD_WALK, 8'($urandom), 8'($urandom));
   endtask

   initial begin
      board = new();
      reset = 1'b1;
      req.valid = 1'b0;
      req.payload = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty walk, missing cases, extremes, duplicates, self loop.
      send_cmd(CMD_WALK, 8'hff, 8'hff);
      send_cmd(CMD_REMOVE, 8'h00, 8'h00);
      send_cmd(CMD_ADD_EDGE, 8'h00, 8'hff);
      send_cmd(CMD_ADD_VERTEX, 8'h00, 8'hff);
      send_cmd(CMD_ADD_VERTEX, 8'hff, 8'h00);
      send_cmd(CMD_ADD_VERTEX, 8'hff, 8'h00);
      send_cmd(CMD_ADD_EDGE, 8'h00, 8'hff);
      send_cmd(CMD_ADD_EDGE, 8'hff, 8'h00);
      send_cmd(CMD_ADD_EDGE, 8'hff, 8'hff);
      send_cmd(CMD_ADD_EDGE, 8'h00, 8'h55);
      send_cmd(CMD_WALK, 8'h00, 8'h00);
      for (int i = 1; i <= 15; i++) send_cmd(CMD_ADD_VERTEX, 8'(i * 16 + 1), 8'h00);
      send_cmd(CMD_ADD_VERTEX, 8'haa, 8'h55);  // full
      // Chain through all vertices so the walk goes the whole depth.
      send_cmd(CMD_ADD_EDGE, 8'hff, 8'h11);
      for (int i = 1; i < 15; i++) send_cmd(CMD_ADD_EDGE, 8'(i * 16 + 1), 8'(i * 16 + 17));
      send_cmd(CMD_WALK, 8'h00, 8'h00);
      send_cmd(CMD_REMOVE, 8'h00, 8'h00);
      send_cmd(CMD_WALK, 8'h00, 8'h00);

      // Pressure: receiver holds off while commands keep coming.
      hold_off = 300;
      for (int i = 0; i < 6; i++) send_cmd(CMD_WALK, 8'h00, 8'h00);

      for (int i = 0; i < 24; i++) pool.push_back(8'($urandom));
      pool.push_back(8'h00);
      pool.push_back(8'hff);
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 22 : 75) : 0;
         recv_stall_pct = (ph == 2) ? 75 : ((ph == 3) ? 22 : 0);
         for (int i = 0; i < 108; i++) random_cmd();
      end
      req.valid <= 1'b0;

      while (board.pending.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (board.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

// File: filelist.f
sv/amgd_pkg.sv
sv/amgd_if.sv
sv/adjacency_matrix_graph_dfs.sv
tb/tb_amgd_board.sv
tb/tb.sv
